@@ design/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value line tokenizer.
// ----------------------------------------------------------------------------
package kvt_pkg;

    typedef enum logic [2:0] {
        KIND_KEY   = 3'd0,
        KIND_VALUE = 3'd1,
        KIND_DONE  = 3'd2,
        KIND_DROP  = 3'd3,
        KIND_END   = 3'd4
    } t_kind;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int RES_SLOTS   = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  text_byte;
        logic [3:0]  entry_number;
        logic [4:0]  entries_found;
    } t_result;

    typedef struct packed {
        t_result [RES_SLOTS-1:0] res;
        logic [1:0]              count;
    } t_bundle;

endpackage

@@ design/key_value_line_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// key_value_line_tokenizer_unit
// Tokenizer for key=value configuration text, one byte per item.
// ----------------------------------------------------------------------------
// A new byte is taken every cycle while the two-bundle queue between the
// classifying front and the output sequencer has room. Each byte yields zero
// to three results, and the output register hands out one result a cycle
// while the receiver is ready; a byte with no result pushes no bundle. An
// accepted byte's results pass through the queue and then the output
// register. There is no clearing pass after reset.
module key_value_line_tokenizer_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_STORE   = 32,
    parameter int VALUE_STORE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_text_byte,
    output logic [3:0] o_entry_number,
    output logic [4:0] o_entries_found,
    output logic       o_run_end
);

    logic             push, pop, full, empty;
    kvt_pkg::t_bundle bundle, head;

    kvt_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_STORE   (KEY_STORE),
        .VALUE_STORE (VALUE_STORE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (full),
        .o_push      (push),
        .o_bundle    (bundle)
    );

    kvt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_full   (full),
        .o_empty  (empty),
        .o_head   (head)
    );

    kvt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_text_byte     (o_text_byte),
        .o_entry_number  (o_entry_number),
        .o_entries_found (o_entries_found),
        .o_run_end       (o_run_end)
    );

endmodule

@@ design/kvt_front.sv @@
// ----------------------------------------------------------------------------
// kvt_front
// Accepts text bytes, runs the line state machine and packs the results of
// one byte into a bundle for the queue.
// ----------------------------------------------------------------------------
module kvt_front #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_STORE   = 32,
    parameter int VALUE_STORE = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_full,
    output logic             o_push,
    output kvt_pkg::t_bundle o_bundle
);

    localparam int KW = $clog2(KEY_STORE);
    localparam int VW = $clog2(VALUE_STORE);
    localparam int TW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        PH_BETWEEN,
        PH_SKIP,
        PH_KEY,
        PH_VALUE,
        PH_DONE
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [KW-1:0]   r_klen, n_klen, klen_cur;
    logic [VW-1:0]   r_vlen, n_vlen;
    logic [TW-1:0]   r_tot, n_tot, idx;
    logic [1:0]      w_cnt;
    kvt_pkg::t_result [kvt_pkg::RES_SLOTS-1:0] w_res;
    logic            key_go;
    logic            take;
    logic            blank;

    function automatic logic [3:0] ent4(input logic [TW-1:0] v);
        logic [TW+3:0] e;
        e = {4'b0, v};
        return e[3:0];
    endfunction

    function automatic logic [4:0] cnt5(input logic [TW-1:0] v);
        logic [TW+4:0] e;
        e = {5'b0, v};
        return e[4:0];
    endfunction

    function automatic kvt_pkg::t_result mk(input kvt_pkg::t_kind k, input logic [7:0] b,
                                            input logic [3:0] en, input logic [4:0] fo);
        kvt_pkg::t_result r;
        r.kind          = k;
        r.text_byte     = b;
        r.entry_number  = en;
        r.entries_found = fo;
        return r;
    endfunction

    assign take  = i_valid && o_ready;
    assign blank = (i_data_byte == kvt_pkg::CH_SPACE) || (i_data_byte == kvt_pkg::CH_TAB) ||
                   (i_data_byte == kvt_pkg::CH_CR) || (i_data_byte == kvt_pkg::CH_LF);

    always_comb begin
        n_phase  = r_phase;
        n_klen   = r_klen;
        n_vlen   = r_vlen;
        n_tot    = r_tot;
        w_cnt    = '0;
        w_res    = '0;
        key_go   = 1'b0;
        klen_cur = r_klen;
        idx      = r_tot;

        unique case (r_phase)
            PH_BETWEEN: begin
                if (blank) begin
                    n_phase = PH_BETWEEN;
                end else if (i_data_byte == kvt_pkg::CH_HASH) begin
                    n_phase = PH_SKIP;
                end else begin
                    n_phase  = PH_KEY;
                    key_go   = 1'b1;
                    klen_cur = '0;
                    n_klen   = '0;
                end
            end
            PH_SKIP: begin
                if (i_data_byte == kvt_pkg::CH_LF) begin
                    n_phase = PH_BETWEEN;
                end
            end
            PH_KEY: begin
                key_go = 1'b1;
            end
            PH_VALUE: begin
                if (i_data_byte == kvt_pkg::CH_LF || i_data_byte == kvt_pkg::CH_CR) begin
                    idx   = n_tot;
                    n_tot = n_tot + 1'b1;
                    w_res[w_cnt] = mk(kvt_pkg::KIND_DONE, 8'd0, ent4(idx), cnt5(n_tot));
                    w_cnt = w_cnt + 2'd1;
                    n_phase = (n_tot >= TW'(MAX_ENTRIES)) ? PH_DONE : PH_BETWEEN;
                end else begin
                    w_res[w_cnt] = mk(kvt_pkg::KIND_VALUE, i_data_byte, ent4(n_tot),
                                      cnt5(n_tot));
                    w_cnt  = w_cnt + 2'd1;
                    n_vlen = r_vlen + 1'b1;
                    if (n_vlen >= VW'(VALUE_STORE - 1)) begin
                        idx   = n_tot;
                        n_tot = n_tot + 1'b1;
                        w_res[w_cnt] = mk(kvt_pkg::KIND_DONE, 8'd0, ent4(idx), cnt5(n_tot));
                        w_cnt = w_cnt + 2'd1;
                        n_phase = (n_tot >= TW'(MAX_ENTRIES)) ? PH_DONE : PH_BETWEEN;
                    end
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_BETWEEN;
            end
        endcase

        if (key_go) begin
            if (i_data_byte == kvt_pkg::CH_EQ) begin
                n_phase = PH_VALUE;
                n_vlen  = '0;
            end else if (i_data_byte == kvt_pkg::CH_LF) begin
                w_res[w_cnt] = mk(kvt_pkg::KIND_DROP, 8'd0, ent4(n_tot), cnt5(n_tot));
                w_cnt   = w_cnt + 2'd1;
                n_phase = PH_BETWEEN;
            end else if (klen_cur < KW'(KEY_STORE - 1)) begin
                w_res[w_cnt] = mk(kvt_pkg::KIND_KEY, i_data_byte, ent4(n_tot), cnt5(n_tot));
                w_cnt  = w_cnt + 2'd1;
                n_klen = klen_cur + 1'b1;
            end else begin
                w_res[w_cnt] = mk(kvt_pkg::KIND_DROP, 8'd0, ent4(n_tot), cnt5(n_tot));
                w_cnt   = w_cnt + 2'd1;
                n_phase = PH_SKIP;
            end
        end

        if (i_last_byte) begin
            if (n_phase == PH_KEY) begin
                w_res[w_cnt] = mk(kvt_pkg::KIND_DROP, 8'd0, ent4(n_tot), cnt5(n_tot));
                w_cnt = w_cnt + 2'd1;
            end else if (n_phase == PH_VALUE) begin
                idx   = n_tot;
                n_tot = n_tot + 1'b1;
                w_res[w_cnt] = mk(kvt_pkg::KIND_DONE, 8'd0, ent4(idx), cnt5(n_tot));
                w_cnt = w_cnt + 2'd1;
            end
            w_res[w_cnt] = mk(kvt_pkg::KIND_END, 8'd0, 4'd0, cnt5(n_tot));
            w_cnt   = w_cnt + 2'd1;
            n_phase = PH_BETWEEN;
            n_klen  = '0;
            n_vlen  = '0;
            n_tot   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BETWEEN;
            r_klen  <= '0;
            r_vlen  <= '0;
            r_tot   <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            r_klen  <= n_klen;
            r_vlen  <= n_vlen;
            r_tot   <= n_tot;
        end
    end

    assign o_ready        = !i_full;
    assign o_push         = take && (w_cnt != 2'd0);
    assign o_bundle.res   = w_res;
    assign o_bundle.count = w_cnt;

endmodule

@@ design/kvt_queue.sv @@
// ----------------------------------------------------------------------------
// kvt_queue
// Short queue of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module kvt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kvt_pkg::t_bundle i_bundle,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output kvt_pkg::t_bundle o_head
);

    localparam int DEPTH = kvt_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    kvt_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

endmodule

@@ design/kvt_back.sv @@
// ----------------------------------------------------------------------------
// kvt_back
// Walks the results of the head bundle into the output register, one a cycle while the output is free.
// ----------------------------------------------------------------------------
module kvt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  kvt_pkg::t_bundle i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_text_byte,
    output logic [3:0]       o_entry_number,
    output logic [4:0]       o_entries_found,
    output logic             o_run_end
);

    logic             r_valid;
    logic [1:0]       r_slot;
    kvt_pkg::t_result r_res;
    logic             r_run_end;
    logic             load;
    logic             at_last;

    assign load    = !i_empty && (!r_valid || i_ready);
    assign at_last = (r_slot == (i_head.count - 2'd1));
    assign o_pop   = load && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_slot  <= at_last ? 2'd0 : r_slot + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res     <= i_head.res[r_slot];
            r_run_end <= at_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_res.kind;
    assign o_text_byte     = r_res.text_byte;
    assign o_entry_number  = r_res.entry_number;
    assign o_entries_found = r_res.entries_found;
    assign o_run_end       = r_run_end;

endmodule

@@ design/kvt_checker.sv @@
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module kvt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_kind,
    input logic [7:0] o_text_byte,
    input logic [3:0] o_entry_number,
    input logic [4:0] o_entries_found,
    input logic       o_run_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_text_byte) &&
        $stable(o_entry_number) && $stable(o_entries_found) && $stable(o_run_end))
        else $error("output item changed while stalled");

    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == kvt_pkg::KIND_END |->
        o_run_end && o_entry_number == 4'd0 && o_text_byte == 8'd0)
        else $error("buffer end item malformed");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == kvt_pkg::KIND_DONE |->
        o_entries_found[3:0] == 4'(o_entry_number + 4'd1))
        else $error("entry count does not follow completed entry");

    a_marker_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == kvt_pkg::KIND_DONE || o_kind == kvt_pkg::KIND_DROP) |->
        o_text_byte == 8'd0)
        else $error("marker item carries a text byte");

endmodule

bind key_value_line_tokenizer_unit kvt_checker u_kvt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_kind          (o_kind),
    .o_text_byte     (o_text_byte),
    .o_entry_number  (o_entry_number),
    .o_entries_found (o_entries_found),
    .o_run_end       (o_run_end)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key/value line tokenizer. Directed and random
// configuration texts are fed byte by byte from a queue; an in-bench tokenizer
// predicts every result and a monitor checks each field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES    = 16;
    localparam int KEY_STORE      = 32;
    localparam int VALUE_STORE    = 64;
    localparam int RANDOM_ITEMS   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int NUM_PHASES     = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_item;

    typedef struct packed {
        kvt_pkg::t_result res;
        logic             run_end;
    } t_token;

    typedef enum logic [2:0] {
        SCAN_BETWEEN,
        SCAN_SKIP,
        SCAN_KEY,
        SCAN_VALUE,
        SCAN_DONE
    } t_scan;

    typedef enum int {
        LN_BLANK,
        LN_COMMENT,
        LN_BARE_KEY,
        LN_LONG_KEY,
        LN_FULL_VALUE,
        LN_ENTRY
    } t_line;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [7:0] i_data_byte     = 8'h00;
    logic       i_last_byte     = 1'b0;
    logic       i_ready         = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_kind;
    logic [7:0] o_text_byte;
    logic [3:0] o_entry_number;
    logic [4:0] o_entries_found;
    logic       o_run_end;

    int send_idle_plan [NUM_PHASES] = '{0, 83, 0, 15};
    int recv_stall_plan[NUM_PHASES] = '{0, 0, 83, 15};
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;

    t_text_item text_q[$];
    logic [7:0] buf_bytes[$];

    // tokenizer state mirrored in the bench
    t_scan  scan_state = SCAN_BETWEEN;
    int     key_len    = 0;
    int     val_len    = 0;
    int     entry_cnt  = 0;
    t_token step_tokens[$];
    t_token expected_tokens[$];

    key_value_line_tokenizer_unit #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_STORE   (KEY_STORE),
        .VALUE_STORE (VALUE_STORE)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_text_byte     (o_text_byte),
        .o_entry_number  (o_entry_number),
        .o_entries_found (o_entries_found),
        .o_run_end       (o_run_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_token(kvt_pkg::t_kind kind, logic [7:0] text, int idx);
        t_token tok;
        tok.res.kind          = kind;
        tok.res.text_byte     = text;
        tok.res.entry_number  = idx[3:0];
        tok.res.entries_found = entry_cnt[4:0];
        tok.run_end           = 1'b0;
        step_tokens.push_back(tok);
    endfunction

    function automatic void close_entry();
        int idx = entry_cnt;
        entry_cnt++;
        add_token(kvt_pkg::KIND_DONE, 8'h00, idx);
        scan_state = (entry_cnt >= MAX_ENTRIES) ? SCAN_DONE : SCAN_BETWEEN;
    endfunction

    function automatic void key_char(logic [7:0] c);
        if (c == kvt_pkg::CH_EQ) begin
            scan_state = SCAN_VALUE;
            val_len    = 0;
        end else if (c == kvt_pkg::CH_LF) begin
            add_token(kvt_pkg::KIND_DROP, 8'h00, entry_cnt);
            scan_state = SCAN_BETWEEN;
        end else if (key_len < KEY_STORE - 1) begin
            add_token(kvt_pkg::KIND_KEY, c, entry_cnt);
            key_len++;
        end else begin
            add_token(kvt_pkg::KIND_DROP, 8'h00, entry_cnt);
            scan_state = SCAN_SKIP;
        end
    endfunction

    function automatic void value_char(logic [7:0] c);
        if (c == kvt_pkg::CH_LF || c == kvt_pkg::CH_CR) begin
            close_entry();
        end else begin
            add_token(kvt_pkg::KIND_VALUE, c, entry_cnt);
            val_len++;
            if (val_len >= VALUE_STORE - 1) begin
                close_entry();
            end
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] c, logic last);
        t_token tok;
        step_tokens.delete();
        case (scan_state)
            SCAN_BETWEEN: begin
                if (c inside {kvt_pkg::CH_SPACE, kvt_pkg::CH_TAB, kvt_pkg::CH_CR,
                              kvt_pkg::CH_LF}) begin
                end else if (c == kvt_pkg::CH_HASH) begin
                    scan_state = SCAN_SKIP;
                end else begin
                    scan_state = SCAN_KEY;
                    key_len    = 0;
                    key_char(c);
                end
            end
            SCAN_SKIP: begin
                if (c == kvt_pkg::CH_LF) begin
                    scan_state = SCAN_BETWEEN;
                end
            end
            SCAN_KEY:   key_char(c);
            SCAN_VALUE: value_char(c);
            default: ;
        endcase
        if (last) begin
            if (scan_state == SCAN_KEY) begin
                add_token(kvt_pkg::KIND_DROP, 8'h00, entry_cnt);
            end else if (scan_state == SCAN_VALUE) begin
                close_entry();
            end
            add_token(kvt_pkg::KIND_END, 8'h00, 0);
            scan_state = SCAN_BETWEEN;
            key_len    = 0;
            val_len    = 0;
            entry_cnt  = 0;
        end
        if (step_tokens.size() > 0) begin
            tok         = step_tokens.pop_back();
            tok.run_end = 1'b1;
            step_tokens.push_back(tok);
        end
        foreach (step_tokens[i]) begin
            expected_tokens.push_back(step_tokens[i]);
        end
    endfunction

    function automatic void push_byte(logic [7:0] data, logic last);
        t_text_item item;
        item.data = data;
        item.last = last;
        text_q.push_back(item);
    endfunction

    function automatic void push_text(string s, bit last_at_end);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], last_at_end && (i == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] rand_key_byte(bit first);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == kvt_pkg::CH_EQ || c == kvt_pkg::CH_LF ||
                   (first && (c inside {kvt_pkg::CH_SPACE, kvt_pkg::CH_TAB,
                                        kvt_pkg::CH_CR, kvt_pkg::CH_HASH})));
        return c;
    endfunction

    function automatic logic [7:0] rand_value_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == kvt_pkg::CH_CR || c == kvt_pkg::CH_LF);
        return c;
    endfunction

    function automatic void add_key(int n);
        for (int i = 0; i < n; i++) begin
            buf_bytes.push_back(rand_key_byte(i == 0));
        end
    endfunction

    function automatic void add_value(int n);
        repeat (n) buf_bytes.push_back(rand_value_byte());
    endfunction

    function automatic void add_line(t_line kind);
        logic [7:0] blanks[4] = '{kvt_pkg::CH_SPACE, kvt_pkg::CH_TAB, kvt_pkg::CH_CR,
                                  kvt_pkg::CH_LF};
        case (kind)
            LN_BLANK: begin
                repeat ($urandom_range(1, 3)) begin
                    buf_bytes.push_back(blanks[2'($urandom_range(3))]);
                end
            end
            LN_COMMENT: begin
                buf_bytes.push_back(kvt_pkg::CH_HASH);
                add_value($urandom_range(0, 6));
                buf_bytes.push_back(kvt_pkg::CH_LF);
            end
            LN_BARE_KEY: begin
                add_key($urandom_range(1, 5));
                buf_bytes.push_back(kvt_pkg::CH_LF);
            end
            LN_LONG_KEY: begin
                add_key($urandom_range(KEY_STORE - 2, KEY_STORE + 1));
                buf_bytes.push_back(kvt_pkg::CH_EQ);
                add_value($urandom_range(0, 3));
                buf_bytes.push_back(kvt_pkg::CH_LF);
            end
            LN_FULL_VALUE: begin
                add_key($urandom_range(1, 3));
                buf_bytes.push_back(kvt_pkg::CH_EQ);
                add_value($urandom_range(VALUE_STORE - 3, VALUE_STORE + 1));
                buf_bytes.push_back(kvt_pkg::CH_LF);
            end
            default: begin
                add_key($urandom_range(0, 6));
                buf_bytes.push_back(kvt_pkg::CH_EQ);
                add_value($urandom_range(0, 8));
                case ($urandom_range(2))
                    0: buf_bytes.push_back(kvt_pkg::CH_CR);
                    1: buf_bytes.push_back(kvt_pkg::CH_LF);
                    default: begin
                        buf_bytes.push_back(kvt_pkg::CH_CR);
                        buf_bytes.push_back(kvt_pkg::CH_LF);
                    end
                endcase
            end
        endcase
    endfunction

    function automatic t_line pick_line();
        int r = $urandom_range(15);
        if (r < 2)   return LN_BLANK;
        if (r == 2)  return LN_COMMENT;
        if (r == 3)  return LN_BARE_KEY;
        if (r == 4)  return LN_LONG_KEY;
        if (r == 5)  return LN_FULL_VALUE;
        return LN_ENTRY;
    endfunction

    function automatic void flush_buffer();
        foreach (buf_bytes[i]) begin
            push_byte(buf_bytes[i], i == buf_bytes.size() - 1);
        end
        buf_bytes.delete();
    endfunction

    function automatic void add_random_buffer();
        buf_bytes.delete();
        case ($urandom_range(9))
            0: repeat ($urandom_range(4, 20)) buf_bytes.push_back(8'($urandom_range(255)));
            1: begin
                // enough short entries to hit the entry limit
                repeat ($urandom_range(MAX_ENTRIES, MAX_ENTRIES + 3)) begin
                    add_key($urandom_range(0, 1));
                    buf_bytes.push_back(kvt_pkg::CH_EQ);
                    add_value($urandom_range(0, 1));
                    buf_bytes.push_back(kvt_pkg::CH_LF);
                end
            end
            default: repeat ($urandom_range(1, 5)) add_line(pick_line());
        endcase
        // unterminated line at buffer end
        if ($urandom_range(1)) begin
            add_key($urandom_range(1, 4));
            if ($urandom_range(1)) begin
                buf_bytes.push_back(kvt_pkg::CH_EQ);
                add_value($urandom_range(0, 4));
            end
        end
        flush_buffer();
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_text_item item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                tokenize_byte(i_data_byte, i_last_byte);
            end
            if (!i_valid || o_ready) begin
                if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = text_q.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= item.data;
                    i_last_byte <= item.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected result: kind %0d text %0h", o_kind, o_text_byte);
                    mismatch_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_kind !== want.res.kind) begin
                        $error("kind: expected %0d, actual %0d", want.res.kind, o_kind);
                        mismatch_count++;
                    end
                    if (o_text_byte !== want.res.text_byte) begin
                        $error("text_byte: expected %0h, actual %0h",
                               want.res.text_byte, o_text_byte);
                        mismatch_count++;
                    end
                    if (o_entry_number !== want.res.entry_number) begin
                        $error("entry_number: expected %0d, actual %0d",
                               want.res.entry_number, o_entry_number);
                        mismatch_count++;
                    end
                    if (o_entries_found !== want.res.entries_found) begin
                        $error("entries_found: expected %0d, actual %0d",
                               want.res.entries_found, o_entries_found);
                        mismatch_count++;
                    end
                    if (o_run_end !== want.run_end) begin
                        $error("run_end: expected %0d, actual %0d", want.run_end, o_run_end);
                        mismatch_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("key_value_line_tokenizer_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        int target;
        send_idle_pct  = send_idle_plan[0];
        recv_stall_pct = recv_stall_plan[0];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // blanks, comment, empty key and value, odd key bytes, drops, buffer ends
        push_text(" \t\r\n#=", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("\n=\na\t#\r=", 1'b0);
        push_byte(8'h00, 1'b0);
        push_text("=#\rk\nv", 1'b1);
        push_text("x=y", 1'b1);
        push_text(" ", 1'b1);

        // key at the length limit, key past it, value around the store limit
        add_key(KEY_STORE - 1);
        buf_bytes.push_back(kvt_pkg::CH_EQ);
        add_value(2);
        buf_bytes.push_back(kvt_pkg::CH_LF);
        add_key(KEY_STORE);
        buf_bytes.push_back(kvt_pkg::CH_EQ);
        buf_bytes.push_back(kvt_pkg::CH_LF);
        add_line(LN_FULL_VALUE);
        flush_buffer();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = send_idle_plan[p];
            recv_stall_pct = recv_stall_plan[p];
            target = text_q.size() + RANDOM_ITEMS;
            while (text_q.size() < target) begin
                add_random_buffer();
            end
            while (text_q.size() != 0) @(posedge i_clk);
        end

        while (text_q.size() != 0 || i_valid || expected_tokens.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("key_value_line_tokenizer_unit test passed");
        end else begin
            $display("key_value_line_tokenizer_unit test failed");
        end
        $finish;
    end

endmodule
